// File: rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length/sum8 deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

  // sync sequence
  localparam logic [7:0] SYNC_A = 8'h1A;
  localparam logic [7:0] SYNC_B = 8'h72;
  localparam logic [7:0] SYNC_C = 8'h73;

  // wrapping sum of the three sync bytes
  localparam logic [7:0] SYNC_SUM = 8'(SYNC_A + SYNC_B + SYNC_C);

  // reset value of the length limit
  localparam logic [15:0] MAX_LEN_RST = 16'hFFFF;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_OVER = 2'd3;

  // receive phase
  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_SYNC2 = 3'd2,
    PH_LENHI = 3'd3,
    PH_LENLO = 3'd4,
    PH_BODY  = 3'd5
  } phase_t;

  // one result from the state step
  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] plen;
  } res_t;

endpackage

// File: rtl/sync_length_sum8_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_sum8_deframer_unit
// Hunts sync 1A 72 73, reads a length, passes payload bytes, checks sum8.
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register, then the state step puts its
//   result, if any, into the result register, which raises out_valid
// throughput: one byte per cycle while the result register is free or being taken
// reset: synchronous rst_n; hunt restarts at the first sync byte, counters
//   and sum clear, max_length returns to 65535, no result pending
module sync_length_sum8_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_payload_length
);

  logic [15:0]   max_len_r;
  logic          adv_ok;
  logic          step_en;
  logic [7:0]    step_byte;
  sld_pkg::res_t res;

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= sld_pkg::MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  sld_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .adv_ok    (adv_ok),
    .step_en   (step_en),
    .step_byte (step_byte)
  );

  sld_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .step_byte(step_byte),
    .max_len  (max_len_r),
    .res      (res)
  );

  sld_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_en           (step_en),
    .res               (res),
    .adv_ok            (adv_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_frame_status  (out_frame_status),
    .out_payload_length(out_payload_length)
  );

  // payload results carry no status and no length
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sld_pkg::KIND_DATA |->
      out_frame_status == sld_pkg::ST_OK && out_payload_length == 16'd0)
    else $error("payload result with status or length");

  // frame end carries no byte, and length errors report zero length
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sld_pkg::KIND_END |-> out_byte == 8'd0 &&
      (out_frame_status == sld_pkg::ST_OK || out_frame_status == sld_pkg::ST_CSUM ||
       out_payload_length == 16'd0))
    else $error("bad frame end fields");

  // a stalled result never lets a new byte step through
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !step_en)
    else $error("step while result stalled");

endmodule

// File: rtl/sld_in_reg.sv
// ----------------------------------------------------------------------------
// sld_in_reg
// Input register for received bytes; hands one byte per cycle to the step while the result side can take it.
// ----------------------------------------------------------------------------
module sld_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       adv_ok,
  output logic       step_en,
  output logic [7:0] step_byte
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       take;

  // held byte moves on when the result side can take it
  assign step_en   = vld_r && adv_ok;
  assign step_byte = byte_r;
  assign in_stall  = vld_r && !adv_ok;
  assign take      = in_valid && !in_stall;

  // occupancy
  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (step_en) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// File: rtl/sld_core.sv
// ----------------------------------------------------------------------------
// sld_core
// Per-byte state step: sync hunt, length capture and checks, payload pass and checksum.
// ----------------------------------------------------------------------------
module sld_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    step_byte,
  input  logic [15:0]   max_len,
  output sld_pkg::res_t res
);

  sld_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      len_hi_r, len_hi_nxt;
  logic [15:0]     left_r, left_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [15:0]     count_r, count_nxt;
  logic [15:0]     len;

  assign len = {len_hi_r, step_byte};

  // next state and result
  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    res        = '0;
    if (step_en) begin
      case (phase_r)
        sld_pkg::PH_SYNC0: begin
          phase_nxt = (step_byte == sld_pkg::SYNC_A) ? sld_pkg::PH_SYNC1 : sld_pkg::PH_SYNC0;
        end
        sld_pkg::PH_SYNC1: begin
          phase_nxt = (step_byte == sld_pkg::SYNC_B) ? sld_pkg::PH_SYNC2 : sld_pkg::PH_SYNC0;
        end
        sld_pkg::PH_SYNC2: begin
          phase_nxt = (step_byte == sld_pkg::SYNC_C) ? sld_pkg::PH_LENHI : sld_pkg::PH_SYNC0;
        end
        sld_pkg::PH_LENHI: begin
          len_hi_nxt = step_byte;
          phase_nxt  = sld_pkg::PH_LENLO;
        end
        sld_pkg::PH_LENLO: begin
          if (len == 16'd0) begin
            phase_nxt  = sld_pkg::PH_SYNC0;
            res.vld    = 1'b1;
            res.kind   = sld_pkg::KIND_END;
            res.status = sld_pkg::ST_ZERO;
          end else if (len > max_len) begin
            phase_nxt  = sld_pkg::PH_SYNC0;
            res.vld    = 1'b1;
            res.kind   = sld_pkg::KIND_END;
            res.status = sld_pkg::ST_OVER;
          end else begin
            left_nxt  = len;
            count_nxt = 16'd0;
            sum_nxt   = sld_pkg::SYNC_SUM + len_hi_r + step_byte;
            phase_nxt = sld_pkg::PH_BODY;
          end
        end
        sld_pkg::PH_BODY: begin
          if (left_r > 16'd1) begin
            sum_nxt   = sum_r + step_byte;
            left_nxt  = left_r - 16'd1;
            count_nxt = count_r + 16'd1;
            res.vld   = 1'b1;
            res.kind  = sld_pkg::KIND_DATA;
            res.data  = step_byte;
          end else begin
            // checksum byte closes the frame
            phase_nxt  = sld_pkg::PH_SYNC0;
            left_nxt   = 16'd0;
            res.vld    = 1'b1;
            res.kind   = sld_pkg::KIND_END;
            res.status = (step_byte == sum_r) ? sld_pkg::ST_OK : sld_pkg::ST_CSUM;
            res.plen   = count_r;
          end
        end
        default: begin
          phase_nxt = sld_pkg::PH_SYNC0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sld_pkg::PH_SYNC0;
      len_hi_r <= 8'd0;
      left_r   <= 16'd0;
      sum_r    <= 8'd0;
      count_r  <= 16'd0;
    end else begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
    end
  end

  // a step in the body always yields a result
  a_body_res: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == sld_pkg::PH_BODY |-> res.vld)
    else $error("body byte without result");

  // payload results come only from the body with bytes still ahead
  a_data_src: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.kind == sld_pkg::KIND_DATA |-> phase_r == sld_pkg::PH_BODY && left_r > 16'd1)
    else $error("payload result outside body");

  // the body never runs with an empty count
  a_left_nz: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sld_pkg::PH_BODY |-> left_r != 16'd0)
    else $error("body with zero bytes left");

endmodule

// File: rtl/sld_out_reg.sv
// ----------------------------------------------------------------------------
// sld_out_reg
// Result register; loads a new result when empty or in the cycle the old one is taken.
// ----------------------------------------------------------------------------
module sld_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  sld_pkg::res_t res,
  output logic          adv_ok,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_frame_status,
  output logic [15:0]   out_payload_length
);

  logic          vld_r;
  logic          vld_nxt;
  sld_pkg::res_t res_r;
  logic          load;

  // free now, or freed by the transaction at this edge
  assign adv_ok = !vld_r || !out_stall;
  assign load   = step_en && res.vld;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid          = vld_r;
  assign out_kind           = res_r.kind;
  assign out_byte           = res_r.data;
  assign out_frame_status   = res_r.status;
  assign out_payload_length = res_r.plen;

endmodule
